/* design/triangle_angle_right_check_unit_assert.svh */
// Assertion macros for the triangle right-angle checker.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef TRIANGLE_ANGLE_RIGHT_CHECK_UNIT_ASSERT_SVH
`define TRIANGLE_ANGLE_RIGHT_CHECK_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define TRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// expression must never be true out of reset
`define TRC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define TRC_ASSERT(lbl, prop, msg)
`define TRC_NEVER(lbl, expr, msg)
`endif
`endif

/* design/trc_pkg.sv */
// Shared types, constants and helpers of the triangle right-angle checker.
// No dependencies; used by the division cell, the arcsine cell and the top level.
package trc_pkg;

	localparam int SIDE_W       = 16;
	localparam int FRAC_BITS    = 16;
	localparam int INNER_FRAC   = 30;
	localparam int SERIES_TERMS = 10;
	localparam int DIV_CELLS    = FRAC_BITS;

	localparam logic [31:0] HALF_PI_INNER = 32'd1686629713;
	localparam logic [17:0] HALF_PI_OUT   = 18'd102944;
	localparam logic [17:0] COS_NEG_ONE   = 18'h30000;
	localparam logic [15:0] TOL_RESET     = 16'd1;

	// arcsine series coefficients (2i)!/(4^i (i!)^2 (2i+1)), Q.30
	localparam logic [30:0] ASIN_COEF [SERIES_TERMS] = '{
		31'd1073741824, 31'd178956971, 31'd80530637, 31'd47934903,
		31'd32622364,   31'd24021923,  31'd18632389, 31'd14994637,
		31'd12403652,   31'd10481448
	};

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_ZERO  = 2'd1,
		ERR_CLAMP = 2'd2
	} err_t;

	// one stage of the long-division chain
	typedef struct packed {
		logic        valid;
		logic        zero;
		logic        neg;
		logic        clamped;
		logic [31:0] ab;
		logic [31:0] rem;
		logic [17:0] quo;
	} div_stage_t;

	// one stage of the arcsine series chain
	typedef struct packed {
		logic        valid;
		logic        zero;
		logic        neg;
		logic        clamped;
		logic [16:0] cm;
		logic [30:0] x2;
		logic [61:0] pp;
		logic [61:0] tp;
		logic [31:0] sum;
	} asin_stage_t;

	// round half up from Q.60 to Q.30
	function automatic logic [31:0] rnd30(input logic [61:0] v);
		logic [61:0] t;
		t = v + (62'd1 << (INNER_FRAC - 1));
		return t[61:30];
	endfunction

endpackage

/* design/trc_div_cell.sv */
// One bit of the restoring division that forms the cosine magnitude.
// Depends on trc_pkg.
module trc_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  trc_pkg::div_stage_t d,
	output trc_pkg::div_stage_t q
);
	import trc_pkg::*;

	logic [32:0] dbl;
	logic [32:0] sub;
	logic        take;
	logic        vld_s1;
	div_stage_t  nxt;
	div_stage_t  pay_s1;

	// trial subtract of the doubled remainder
	assign dbl  = {d.rem, 1'b0};
	assign sub  = dbl - {1'b0, d.ab};
	assign take = dbl >= {1'b0, d.ab};

	// next remainder and quotient bit
	always_comb begin
		nxt     = d;
		nxt.rem = take ? sub[31:0] : dbl[31:0];
		nxt.quo = {d.quo[16:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= nxt;
		end
	end

	always_comb begin
		q       = pay_s1;
		q.valid = vld_s1;
	end

endmodule

/* design/trc_asin_cell.sv */
// One term of the arcsine Maclaurin series: rounds the incoming products,
// accumulates the term and forms the next odd power. Depends on trc_pkg.
module trc_asin_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  trc_pkg::asin_stage_t d,
	output trc_pkg::asin_stage_t q
);
	import trc_pkg::*;

	logic [31:0] p_r;
	logic [31:0] t_r;
	logic [30:0] p;
	logic        vld_s1;
	asin_stage_t nxt;
	asin_stage_t pay_s1;

	// previous products back to Q.30
	assign p_r = rnd30(d.pp);
	assign t_r = rnd30(d.tp);
	assign p   = p_r[30:0];

	// running sum, next power and this term
	always_comb begin
		nxt     = d;
		nxt.sum = d.sum + t_r;
		nxt.pp  = {31'd0, p} * {31'd0, d.x2};
		nxt.tp  = {31'd0, ASIN_COEF[IDX]} * {31'd0, p};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= nxt;
		end
	end

	always_comb begin
		q       = pay_s1;
		q.valid = vld_s1;
	end

endmodule

/* design/triangle_angle_right_check_unit.sv */
// Top level of the triangle right-angle checker: sort, law of cosines,
// division and arcsine cell chains, output queue. Depends on trc_pkg and cells.
//
//  channel  | dir | fields (low bit up)
//  s_*      | in  | side_one, side_two, side_three (16 b each)
//  m_*      | out | angle_opposite_longest 18, cosine_value 18, is_right, error_code 2
//  cfg_*    | in  | right_angle_tolerance 16
//
// One request per cycle while the output queue has room; 35 register stages (4 front,
// 16 division, 2, 10 series, 2, queue) lie between a taken request and its result.
// Reset clears all valid bits and sets the tolerance to 1.
// Two-entry output queue: the pipeline freezes only when both entries are full.
`include "triangle_angle_right_check_unit_assert.svh"
module triangle_angle_right_check_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // side_one, side_two, side_three
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // angle_opposite_longest, cosine_value, is_right, error_code
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import trc_pkg::*;

	typedef struct packed {
		err_t        err;
		logic        is_right;
		logic [17:0] cosine;
		logic [17:0] angle;
	} res_t;

	logic        adv;
	logic [15:0] tol_q;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// stage 1: sort so that a <= b <= c
	logic [15:0] a0, b0, c0, a1, b1, b2, c2, a3, b3;
	logic [15:0] a_s1, b_s1, c_s1;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	assign a0 = s_tdata[15:0];
	assign b0 = s_tdata[31:16];
	assign c0 = s_tdata[47:32];
	assign a1 = (a0 > b0) ? b0 : a0;
	assign b1 = (a0 > b0) ? a0 : b0;
	assign b2 = (b1 > c0) ? c0 : b1;
	assign c2 = (b1 > c0) ? b1 : c0;
	assign a3 = (a1 > b2) ? b2 : a1;
	assign b3 = (a1 > b2) ? a1 : b2;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= a3;
			b_s1 <= b3;
			c_s1 <= c2;
		end
	end

	// stage 2: squares and cross product
	logic [31:0] aa_s2, bb_s2, cc_s2, ab_s2;
	logic        zero_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			aa_s2   <= {16'd0, a_s1} * {16'd0, a_s1};
			bb_s2   <= {16'd0, b_s1} * {16'd0, b_s1};
			cc_s2   <= {16'd0, c_s1} * {16'd0, c_s1};
			ab_s2   <= {16'd0, a_s1} * {16'd0, b_s1};
			zero_s2 <= a_s1 == '0;
		end
	end

	// stage 3: |a^2 + b^2 - c^2| and its sign
	logic [31:0] d_c, m_s3, ab_s3;
	logic        neg_c, neg_s3, zero_s3;

	assign d_c   = cc_s2 - bb_s2;
	assign neg_c = aa_s2 < d_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3    <= neg_c ? d_c - aa_s2 : aa_s2 - d_c;
			neg_s3  <= neg_c;
			ab_s3   <= ab_s2;
			zero_s3 <= zero_s2;
		end
	end

	// stage 4: clamp test and integer part of the quotient
	logic [32:0] ab2;
	logic        clamp_c, ge2_c, ge1_c;
	div_stage_t  div_chain [DIV_CELLS+1];

	assign ab2     = {ab_s3, 1'b0};
	assign clamp_c = {1'b0, m_s3} > ab2;
	assign ge2_c   = {1'b0, m_s3} == ab2;
	assign ge1_c   = m_s3 >= ab_s3;

	div_stage_t d4_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			d4_s4.valid   <= vld_s3;
			d4_s4.zero    <= zero_s3;
			d4_s4.neg     <= neg_s3;
			d4_s4.clamped <= clamp_c;
			d4_s4.ab      <= ab_s3;
			if (clamp_c || ge2_c) begin
				d4_s4.rem <= '0;
				d4_s4.quo <= clamp_c ? 18'd0 : 18'd2;
			end else if (ge1_c) begin
				d4_s4.rem <= m_s3 - ab_s3;
				d4_s4.quo <= 18'd1;
			end else begin
				d4_s4.rem <= m_s3;
				d4_s4.quo <= 18'd0;
			end
		end
	end

	always_comb begin
		div_chain[0]       = d4_s4;
		div_chain[0].valid = vld_s4;
	end

	// fraction bits of the cosine, one per cell
	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		trc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (div_chain[i]),
			.q      (div_chain[i+1])
		);
	end

	// stage 5: round the magnitude, apply the clamp
	div_stage_t  dq;
	logic [18:0] q_inc;
	logic [16:0] cm_c;
	logic [16:0] cm_s5;
	logic        neg_s5, zero_s5, clamp_s5;

	assign dq    = div_chain[DIV_CELLS];
	assign q_inc = {1'b0, dq.quo} + 19'd1;
	assign cm_c  = dq.clamped ? 17'h10000 : q_inc[17:1];

	always_ff @(posedge clk) begin
		if (adv) begin
			cm_s5    <= cm_c;
			neg_s5   <= dq.neg && (cm_c != '0);
			zero_s5  <= dq.zero;
			clamp_s5 <= dq.clamped;
		end
	end

	// stage 6 (series entry): x squared in Q.30, x as the first power
	asin_stage_t asin_chain [SERIES_TERMS+1];
	asin_stage_t a6_s6;
	logic [33:0] cm_sq;

	assign cm_sq = {17'd0, cm_s5} * {17'd0, cm_s5};

	always_ff @(posedge clk) begin
		if (adv) begin
			a6_s6.valid   <= vld_s5;
			a6_s6.zero    <= zero_s5;
			a6_s6.neg     <= neg_s5;
			a6_s6.clamped <= clamp_s5;
			a6_s6.cm      <= cm_s5;
			a6_s6.x2      <= 31'((cm_sq + 34'd2) >> 2);
			a6_s6.pp      <= {1'b0, cm_s5, 44'd0};
			a6_s6.tp      <= '0;
			a6_s6.sum     <= '0;
		end
	end

	always_comb begin
		asin_chain[0]       = a6_s6;
		asin_chain[0].valid = vld_s6;
	end

	for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_asin
		trc_asin_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (asin_chain[i]),
			.q      (asin_chain[i+1])
		);
	end

	// stage 7: add the last term, stage 8: angle = pi/2 -/+ asin
	asin_stage_t aq;
	logic [31:0] t_last;
	logic [31:0] s_s7;
	logic        neg_s7, zero_s7, clamp_s7;
	logic [16:0] cm_s7;

	assign aq     = asin_chain[SERIES_TERMS];
	assign t_last = rnd30(aq.tp);

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s7     <= aq.sum + t_last;
			neg_s7   <= aq.neg;
			zero_s7  <= aq.zero;
			clamp_s7 <= aq.clamped;
			cm_s7    <= aq.cm;
		end
	end

	logic [31:0] ang_s8;
	logic        neg_s8, zero_s8, clamp_s8, vld_s8;
	logic [16:0] cm_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (neg_s7) begin
				ang_s8 <= HALF_PI_INNER + s_s7;
			end else begin
				ang_s8 <= (s_s7 > HALF_PI_INNER) ? 32'd0 : HALF_PI_INNER - s_s7;
			end
			neg_s8   <= neg_s7;
			zero_s8  <= zero_s7;
			clamp_s8 <= clamp_s7;
			cm_s8    <= cm_s7;
		end
	end

	// final: round to Q2.16, tolerance test, result word
	logic [32:0] ang_rnd;
	logic [17:0] angf;
	logic [17:0] adiff;
	res_t        res_c;

	assign ang_rnd = {1'b0, ang_s8} + 33'd8192;
	assign angf    = ang_rnd[31:14];
	assign adiff   = (angf > HALF_PI_OUT) ? angf - HALF_PI_OUT : HALF_PI_OUT - angf;

	always_comb begin
		if (zero_s8) begin
			res_c.err      = ERR_ZERO;
			res_c.is_right = 1'b0;
			res_c.cosine   = '0;
			res_c.angle    = '0;
		end else begin
			res_c.err      = clamp_s8 ? ERR_CLAMP : ERR_OK;
			res_c.is_right = adiff < {2'b0, tol_q};
			res_c.cosine   = neg_s8 ? 18'd0 - {1'b0, cm_s8} : {1'b0, cm_s8};
			res_c.angle    = angf;
		end
	end

	// valid bits of the stages outside the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= div_chain[DIV_CELLS].valid;
			vld_s6 <= vld_s5;
			vld_s7 <= asin_chain[SERIES_TERMS].valid;
			vld_s8 <= vld_s7;
		end
	end

	// two-entry output queue
	res_t       buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	res_t       res_out;

	assign adv      = cnt_q != 2'd2;
	assign s_tready = adv;
	assign push     = adv && vld_s8;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != 2'd0;
	assign res_out  = buf_q[rd_ptr_q];
	assign m_tdata  = {1'b0, res_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= res_c;
		end
	end

	// checks
	`TRC_ASSERT(a_zero_result, m_tvalid && res_out.err == ERR_ZERO |-> res_out[36:0] == '0, "zero side, non-zero fields")
	`TRC_ASSERT(a_clamp_cos, m_tvalid && res_out.err == ERR_CLAMP |-> res_out.cosine == COS_NEG_ONE, "clamp not -1")
	`TRC_NEVER(a_queue_ovf, push && cnt_q == 2'd2, "output queue overflow")

endmodule
